// ----- rtl/core/rpc_pkg.sv -----
// Shared types, constants and elaboration-time functions for the rectangular/polar converter.
package rpc_pkg;

  localparam int unsigned DW        = 34;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned TAB_LEN   = 24;

  localparam logic [1:0] FORM_RECT  = 2'd0;
  localparam logic [1:0] FORM_POLAR = 2'd1;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43, 32'h0145_D7E1,
    32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D, 32'h0000_28BE, 32'h0000_145F,
    32'h0000_0A30, 32'h0000_0518, 32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct packed {
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic        [1:0]  form;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic        [15:0] magnitude;
    logic signed [15:0] angle;
    logic               mode_out;
    logic               bad_form;
  } result_t;

  typedef struct packed {
    logic                 vect;
    logic                 zero;
    in_item_t             item;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic        [31:0]   z;
  } stage_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > n) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Inverse CORDIC gain in Q30 for the given stage count.
  function automatic logic [30:0] gain_inverse(input int unsigned stages);
    logic [63:0] p;
    logic [63:0] kq;
    logic [63:0] num;
    logic [64:0] rem;
    logic [63:0] q;
    p = 64'd1 << 60;
    for (int unsigned i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    kq  = isqrt64(p);
    num = (64'd1 << 60) + (kq >> 1);
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, kq}) begin
        rem  = rem - {1'b0, kq};
        q[i] = 1'b1;
      end
    end
    return q[30:0];
  endfunction

endpackage

// ----- rtl/core/rect_polar_converter.sv -----
// Top level of the rectangular/polar converter: input cell, CORDIC cell row, compensation.
//
// Usage:
//   Raise start_i with a vector on in_i; the transfer happens at every rising edge
//   where start_i is high and busy_o is low. busy_o is always low, so a new vector
//   may follow in every cycle.
//   form 0 takes (x, y) and returns the magnitude and binary angle; form 1 takes
//   (magnitude, angle) and returns x and y; any other form returns zeros with
//   bad_form set.
//   Each result sits on result_o for exactly one cycle with valid_o high. The input
//   cell loads at the transfer edge; the vector then passes in turn through each
//   CORDIC cell register, the gain multiplier register and the output register.
//   The result is taken at the edge that ends that valid cycle.
//   Throughput is one vector per clock, set by the row of CORDIC_STAGES cells that
//   each hand their vector to the next cell every cycle.
//   The receiver cannot stall; results are delivered in order, spaced as their transfers were.
//   Reset clears all valid flags; nothing in flight survives reset.
module rect_polar_converter #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  rpc_pkg::in_item_t in_i,
  output logic             valid_o,
  output rpc_pkg::result_t result_o
);
  import rpc_pkg::*;

  localparam int unsigned LAT = CORDIC_STAGES + 2;

  logic   accept;
  logic   chain_valid [CORDIC_STAGES+1];
  stage_t chain_stage [CORDIC_STAGES+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rpc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (in_i),
    .valid_o (chain_valid[0]),
    .stage_o (chain_stage[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rpc_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .stage_i (chain_stage[g]),
      .valid_o (chain_valid[g+1]),
      .stage_o (chain_stage[g+1])
    );
  end

  rpc_comp #(
    .STAGES (CORDIC_STAGES)
  ) u_comp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (chain_valid[CORDIC_STAGES]),
    .stage_i  (chain_stage[CORDIC_STAGES]),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT + 1))
    else $error("result without matching transfer");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.bad_form) |->
      (result_o.x_coord == 16'sd0 && result_o.y_coord == 16'sd0 &&
       result_o.magnitude == 16'd0 && result_o.angle == 16'sd0 && !result_o.mode_out))
    else $error("invalid form result not cleared");

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.mode_out) |-> !result_o.bad_form)
    else $error("polar result flagged invalid");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !result_o.mode_out && !result_o.bad_form &&
     result_o.x_coord == 16'sd0 && result_o.y_coord == 16'sd0) |->
      (result_o.magnitude == 16'd0 && result_o.angle == 16'sd0))
    else $error("zero vector gives nonzero polar form");

endmodule

// ----- rtl/core/rpc_prep.sv -----
// Input cell: forms the starting vector and angle for vectoring or rotation.
module rpc_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rpc_pkg::in_item_t item_i,
  output logic              valid_o,
  output rpc_pkg::stage_t   stage_o
);
  import rpc_pkg::*;

  logic                 valid_q;
  stage_t               stage_d, stage_q;
  logic signed [DW-1:0] a_ext, b_ext;
  logic [31:0]          z_rot;

  assign a_ext = DW'(item_i.first_value) <<< FRAC_BITS;
  assign b_ext = DW'(item_i.second_value) <<< FRAC_BITS;
  assign z_rot = {item_i.second_value, 16'h0000};

  always_comb begin
    stage_d      = '0;
    stage_d.item = item_i;
    stage_d.vect = (item_i.form == FORM_RECT);
    stage_d.zero = (item_i.first_value == 16'sd0) && (item_i.second_value == 16'sd0);
    if (stage_d.vect) begin
      if (a_ext[DW-1]) begin
        stage_d.x = -a_ext;
        stage_d.y = -b_ext;
        stage_d.z = 32'h8000_0000;
      end else begin
        stage_d.x = a_ext;
        stage_d.y = b_ext;
        stage_d.z = 32'h0000_0000;
      end
    end else begin
      stage_d.y = '0;
      if (z_rot[31] != z_rot[30]) begin
        stage_d.x = -a_ext;
        stage_d.z = z_rot ^ 32'h8000_0000;
      end else begin
        stage_d.x = a_ext;
        stage_d.z = z_rot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- rtl/core/rpc_cell.sv -----
// CORDIC cell: one micro-rotation by atan(2^-IDX), shared by vectoring and rotation.
module rpc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rpc_pkg::stage_t stage_i,
  output logic            valid_o,
  output rpc_pkg::stage_t stage_o
);
  import rpc_pkg::*;

  logic                 valid_q;
  stage_t               stage_d, stage_q;
  logic                 ccw;
  logic signed [DW-1:0] dx, dy;

  assign ccw = stage_i.vect ? stage_i.y[DW-1] : !stage_i.z[31];
  assign dx  = stage_i.y >>> IDX;
  assign dy  = stage_i.x >>> IDX;

  always_comb begin
    stage_d = stage_i;
    if (ccw) begin
      stage_d.x = stage_i.x - dx;
      stage_d.y = stage_i.y + dy;
      stage_d.z = stage_i.z - ATAN_TAB[IDX];
    end else begin
      stage_d.x = stage_i.x + dx;
      stage_d.y = stage_i.y - dy;
      stage_d.z = stage_i.z + ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- rtl/core/rpc_comp.sv -----
// Gain compensation, rounding, saturation and result assembly.
module rpc_comp #(
  parameter int unsigned STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rpc_pkg::stage_t  stage_i,
  output logic             valid_o,
  output rpc_pkg::result_t result_o
);
  import rpc_pkg::*;

  localparam int unsigned PW = DW + 32;
  localparam logic [30:0] KINV = gain_inverse(STAGES);

  logic                 mvalid_q;
  stage_t               mstage_q;
  logic signed [PW-1:0] px_d, py_d, px_q, py_q;
  logic signed [PW-1:0] rx, ry;
  logic signed [PW-45:0] sx, sy;
  logic [15:0]          mag_sat;
  logic signed [15:0]   x_sat, y_sat;
  logic [31:0]          ang_rnd;
  logic                 ovalid_q;
  result_t              res_d, res_q;

  assign px_d = PW'(stage_i.x) * PW'($signed({1'b0, KINV}));
  assign py_d = PW'(stage_i.y) * PW'($signed({1'b0, KINV}));

  assign rx = px_q + (PW'(1) <<< 43);
  assign ry = py_q + (PW'(1) <<< 43);
  assign sx = rx[PW-1:44];
  assign sy = ry[PW-1:44];

  always_comb begin
    if (sx[PW-45]) begin
      mag_sat = 16'd0;
    end else if (sx > (PW-44)'(65535)) begin
      mag_sat = 16'hFFFF;
    end else begin
      mag_sat = sx[15:0];
    end
    if (sx > (PW-44)'(32767)) begin
      x_sat = 16'sh7FFF;
    end else if (sx < -(PW-44)'(32768)) begin
      x_sat = -16'sh8000;
    end else begin
      x_sat = sx[15:0];
    end
    if (sy > (PW-44)'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (sy < -(PW-44)'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = sy[15:0];
    end
  end

  assign ang_rnd = mstage_q.z + 32'h0000_8000;

  always_comb begin
    res_d = '0;
    unique case (mstage_q.item.form)
      FORM_RECT: begin
        res_d.x_coord   = mstage_q.item.first_value;
        res_d.y_coord   = mstage_q.item.second_value;
        res_d.magnitude = mstage_q.zero ? 16'd0 : mag_sat;
        res_d.angle     = mstage_q.zero ? 16'sd0 : ang_rnd[31:16];
      end
      FORM_POLAR: begin
        res_d.x_coord   = x_sat;
        res_d.y_coord   = y_sat;
        res_d.magnitude = mstage_q.item.first_value;
        res_d.angle     = mstage_q.item.second_value;
        res_d.mode_out  = 1'b1;
      end
      default: begin
        res_d.bad_form = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      mvalid_q <= valid_i;
      ovalid_q <= mvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mstage_q <= stage_i;
      px_q     <= px_d;
      py_q     <= py_d;
    end
    if (mvalid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = ovalid_q;
  assign result_o = res_q;

endmodule
